### sv/rrtg_pkg.sv
// rrtg_pkg: types and constants shared by the rational rate tick generator
// no dependencies; compiled before every other file of the block

package rrtg_pkg;

    // arithmetic widths
    localparam int DIVIDEND_W = 53;   // remainder plus scaled elapsed time stays below 2^53
    localparam int DIVISOR_W  = 40;   // one million times both denominators
    localparam int QUOT_W     = 34;   // quotient stays below 2^34 for any divisor >= 1e6
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [19:0] MICROS_PER_SECOND = 20'd1000000;
    localparam logic [31:0] TICK_CAP          = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_DEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSED    = 3'd4;

    // configuration reset values
    localparam logic [11:0] RATE_NUM_RESET  = 12'd60;
    localparam logic [11:0] RATE_DEN_RESET  = 12'd1;
    localparam logic [7:0]  SPEED_NUM_RESET = 8'd1;
    localparam logic [7:0]  SPEED_DEN_RESET = 8'd1;

    // input item action codes
    localparam logic ACTION_ADVANCE = 1'b0;
    localparam logic ACTION_RESET   = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] elapsed_us;
    } in_item_t;

    typedef struct packed {
        logic [31:0] ticks;
        logic        ticks_capped;
        logic [63:0] total_issued;
        logic [31:0] tick_period_us;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_TICK_GO,
        ST_TICK_DIV,
        ST_PER_GO,
        ST_PER_DIV,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic div_tick;
        logic commit;
        logic div_period;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic result_free;
    } dp_status_t;

endpackage

### sv/rrtg_divider.sv
// rrtg_divider: restoring divider, one quotient bit per cycle
// depends on rrtg_pkg for the operand widths

module rrtg_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [rrtg_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [rrtg_pkg::DIVISOR_W-1:0]   divisor,
    output logic                             busy,
    output logic [rrtg_pkg::QUOT_W-1:0]      quotient,
    output logic [rrtg_pkg::DIVISOR_W-1:0]   remainder
);

    localparam int QW     = rrtg_pkg::QUOT_W;
    localparam int DW     = rrtg_pkg::DIVISOR_W;
    localparam int NW     = rrtg_pkg::DIVIDEND_W;
    localparam int STEP_W = $clog2(QW);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QW - 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     part_reg;
    logic [DW-1:0]     part_next;
    logic [QW-1:0]     low_reg;
    logic [DW-1:0]     divisor_reg;
    logic [DW:0]       trial;
    logic [DW+1:0]     diff;
    logic              fits;

    // shift in the next dividend bit, subtract if it fits
    assign trial     = {part_reg, low_reg[QW-1]};
    assign diff      = {1'b0, trial} - {2'b00, divisor_reg};
    assign fits      = ~diff[DW+1];
    assign part_next = fits ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            part_reg    <= DW'(dividend[NW-1:QW]);
            low_reg     <= dividend[QW-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            part_reg <= part_next;
            low_reg  <= {low_reg[QW-2:0], fits};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = low_reg;
    assign remainder = part_reg;

endmodule

### sv/rrtg_datapath.sv
// rrtg_datapath: configuration registers, multipliers, accumulator, issued count
// and result register; depends on rrtg_pkg and rrtg_divider

module rrtg_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rrtg_pkg::ctrl_cmd_t               cmd,
    output rrtg_pkg::dp_status_t              status,
    input  rrtg_pkg::in_item_t                item,
    input  logic                              cfg_write,
    input  logic [rrtg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrtg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              result_stall,
    output logic                              result_valid,
    output rrtg_pkg::out_item_t               result
);

    localparam int QW = rrtg_pkg::QUOT_W;
    localparam int DW = rrtg_pkg::DIVISOR_W;
    localparam int NW = rrtg_pkg::DIVIDEND_W;

    // configuration
    logic [11:0] rate_num_reg;
    logic [11:0] rate_den_reg;
    logic [7:0]  speed_num_reg;
    logic [7:0]  speed_den_reg;
    logic        paused_reg;
    logic        rate_ok;

    // per-transaction operands
    logic        action_reg;
    logic        active_reg;
    logic [31:0] elapsed_reg;
    logic [43:0] prod1_reg;
    logic [31:0] base_reg;
    logic [51:0] prod2_reg;
    logic [DW-1:0] per_tick_reg;
    logic [NW-1:0] sum_reg;
    logic [QW-1:0] ticks_q_reg;

    // state
    logic [DW-1:0] accum_reg;
    logic [63:0]   issued_reg;

    // result register
    logic                 result_valid_reg;
    rrtg_pkg::out_item_t  result_reg;
    rrtg_pkg::out_item_t  result_next;
    logic                 result_free;

    // divider
    logic          div_start;
    logic [NW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_busy;
    logic [QW-1:0] div_quotient;
    logic [DW-1:0] div_remainder;

    assign rate_ok = (rate_num_reg != '0) && (rate_den_reg != '0);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            rate_num_reg  <= rrtg_pkg::RATE_NUM_RESET;
            rate_den_reg  <= rrtg_pkg::RATE_DEN_RESET;
            speed_num_reg <= rrtg_pkg::SPEED_NUM_RESET;
            speed_den_reg <= rrtg_pkg::SPEED_DEN_RESET;
            paused_reg    <= 1'b0;
        end
        else if (cmd.commit && action_reg == rrtg_pkg::ACTION_RESET)
        begin
            paused_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rrtg_pkg::REG_RATE_NUM:  rate_num_reg  <= cfg_data[11:0];
                rrtg_pkg::REG_RATE_DEN:  rate_den_reg  <= cfg_data[11:0];
                rrtg_pkg::REG_SPEED_NUM: speed_num_reg <= cfg_data[7:0];
                rrtg_pkg::REG_SPEED_DEN: speed_den_reg <= cfg_data[7:0];
                rrtg_pkg::REG_PAUSED:    paused_reg    <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // operand pipeline, one multiply per register
    always_ff @(posedge clk) begin
        if (cmd.load)
        begin
            action_reg  <= item.action;
            elapsed_reg <= item.elapsed_us;
            active_reg  <= (item.action == rrtg_pkg::ACTION_ADVANCE) && rate_ok
                           && (speed_num_reg != '0) && (speed_den_reg != '0)
                           && !paused_reg && (item.elapsed_us != '0);
        end
        if (cmd.mul1)
        begin
            prod1_reg <= 44'(elapsed_reg) * 44'(rate_num_reg);
            base_reg  <= 32'(rrtg_pkg::MICROS_PER_SECOND) * 32'(rate_den_reg);
        end
        if (cmd.mul2)
        begin
            prod2_reg    <= 52'(prod1_reg) * 52'(speed_num_reg);
            per_tick_reg <= 40'(base_reg) * 40'(speed_den_reg);
        end
        if (cmd.sum)
        begin
            sum_reg <= NW'(accum_reg) + NW'(prod2_reg);
        end
        if (cmd.commit)
        begin
            ticks_q_reg <= (active_reg && action_reg == rrtg_pkg::ACTION_ADVANCE)
                           ? div_quotient : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            accum_reg  <= '0;
            issued_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (action_reg == rrtg_pkg::ACTION_RESET)
            begin
                accum_reg  <= '0;
                issued_reg <= '0;
            end
            else if (active_reg)
            begin
                accum_reg  <= div_remainder;
                issued_reg <= issued_reg + 64'(div_quotient);
            end
        end
    end

    // shared divider: ticks first, then the period
    assign div_start    = cmd.div_tick | cmd.div_period;
    assign div_dividend = cmd.div_period ? NW'(base_reg) : sum_reg;
    assign div_divisor  = cmd.div_period ? DW'(rate_num_reg) : per_tick_reg;

    rrtg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb begin
        result_next.ticks          = (|ticks_q_reg[QW-1:32]) ? rrtg_pkg::TICK_CAP
                                                             : ticks_q_reg[31:0];
        result_next.ticks_capped   = |ticks_q_reg[QW-1:32];
        result_next.total_issued   = issued_reg;
        result_next.tick_period_us = rate_ok ? div_quotient[31:0] : '0;
    end

    assign result_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign status.div_busy    = div_busy;
    assign status.result_free = result_free;
    assign result_valid       = result_valid_reg;
    assign result             = result_reg;

endmodule

### sv/rrtg_ctrl.sv
// rrtg_ctrl: sequencing state machine for one transaction at a time
// depends on rrtg_pkg for the state type and the command and status structs

module rrtg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  rrtg_pkg::dp_status_t  status,
    output rrtg_pkg::ctrl_cmd_t   cmd
);

    rrtg_pkg::ctrl_state_t state_reg;
    rrtg_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= rrtg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            rrtg_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rrtg_pkg::ST_MUL1;
                end
            end
            rrtg_pkg::ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = rrtg_pkg::ST_MUL2;
            end
            rrtg_pkg::ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = rrtg_pkg::ST_SUM;
            end
            rrtg_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = rrtg_pkg::ST_TICK_GO;
            end
            rrtg_pkg::ST_TICK_GO:
            begin
                cmd.div_tick = 1'b1;
                state_next   = rrtg_pkg::ST_TICK_DIV;
            end
            rrtg_pkg::ST_TICK_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = rrtg_pkg::ST_PER_GO;
                end
            end
            rrtg_pkg::ST_PER_GO:
            begin
                cmd.div_period = 1'b1;
                state_next     = rrtg_pkg::ST_PER_DIV;
            end
            rrtg_pkg::ST_PER_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = rrtg_pkg::ST_EMIT;
                end
            end
            rrtg_pkg::ST_EMIT:
            begin
                if (status.result_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rrtg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrtg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/rational_rate_tick_generator.sv
// rational_rate_tick_generator: top level of the rational rate tick generator
// depends on rrtg_pkg, rrtg_ctrl, rrtg_datapath (which holds rrtg_divider)

// Converts elapsed microseconds into whole ticks of a rational tick rate played at a
// rational speed. An advance transaction adds elapsed_us * rate_numerator *
// speed_numerator to a 40-bit remainder and divides by 1e6 * rate_denominator *
// speed_denominator; the quotient is the tick count (reported saturated at 2^32-1
// with ticks_capped), the remainder is kept, and a 64-bit issued count grows.
// Paused, zero elapsed time, a zero rate or a zero speed give zero ticks and leave
// the state alone. A reset transaction clears remainder, issued count and paused.
// Every result carries the tick period 1e6 * rate_denominator / rate_numerator, or
// zero when the rate is zero. One transaction is in work at a time: from acceptance
// to the result register it passes the shared restoring divider, used first for the
// tick quotient and then for the period (a start step, the quotient bits one by one
// and a step to see it done), plus two multiply steps, a sum step and the emit step.
// A new transaction is taken only once the last has reached the result register. The
// result register lets the next transaction enter while the previous result waits.
// Configuration registers (index: 0 rate_numerator, 1 rate_denominator,
// 2 speed_numerator, 3 speed_denominator, 4 paused) are always ready and are to be
// written only while the block is idle; other indexes are ignored.

module rational_rate_tick_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    // input transactions
    input  logic                              item_valid,
    output logic                              item_stall,
    input  rrtg_pkg::in_item_t                item,
    // result transactions
    output logic                              result_valid,
    input  logic                              result_stall,
    output rrtg_pkg::out_item_t               result,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rrtg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrtg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rrtg_pkg::ctrl_cmd_t  cmd;
    rrtg_pkg::dp_status_t status;
    logic                 cfg_write;

    // register file is always ready; a write made as a reset transaction commits is lost
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // sequencer: load, two multiply steps, sum, tick divide, period divide, emit
    rrtg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // arithmetic, state and the result register
    rrtg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### sv/rrtg_checker.sv
// rrtg_checker: port-level assertions for the rational rate tick generator
// depends on rrtg_pkg; bound to rational_rate_tick_generator at the end of this file

module rrtg_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input rrtg_pkg::out_item_t  result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

    // the capped flag comes only with a saturated count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.ticks_capped) |-> (result.ticks == rrtg_pkg::TICK_CAP))
        else $error("capped result without saturated ticks");

    // an accepted transaction occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input taken again right after a transaction");

    // the block is still busy after both multiply steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |-> ##3 item_stall)
        else $error("transaction finished too early");

endmodule

bind rational_rate_tick_generator rrtg_checker u_rrtg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
